@@ hw/rtl/assert_macros.svh @@
// Assertion helpers. Every user has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hw/rtl/rdw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rdw_pkg;

  localparam int unsigned ElemWidthDefault = 64;
  localparam int unsigned WordWidth        = 64;
  localparam int unsigned CountWidth       = 48;
  localparam int unsigned CfgIdxWidth      = 2;
  localparam int unsigned InDataWidth      = 8;
  localparam int unsigned OutDataWidth     = 368;

  localparam logic [CountWidth-1:0] CountMax  = {CountWidth{1'b1}};
  localparam logic [CountWidth-1:0] CountStep = CountWidth'(3);

  // walker index of the last step of a round (tortoise 0, hare 1 and 2)
  localparam logic [1:0] LastStep = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_GROUP_ORDER = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_GENERATOR   = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_TARGET      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_R_SET, S_LOAD, S_DX, S_DOP, S_MUL,
    S_DGE, S_DHE, S_EXP, S_NEXT, S_OUT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_RESTART, OP_LOAD, OP_DIV_X, OP_DIV_OP,
    OP_MUL, OP_DIV_GE, OP_DIV_HE, OP_EXP, OP_COUNT, OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    KIND_H, KIND_SQ, KIND_G
  } step_kind_e;

  typedef enum logic [1:0] {
    DIV_IDLE, DIV_RUN, DIV_DONE
  } div_state_e;

  typedef enum logic [1:0] {
    MUL_IDLE, MUL_DBL, MUL_ADD, MUL_DONE
  } mul_state_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel;   // 0 tortoise, 1 hare
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic n_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rdw_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle; early out when dividend < divisor.
// Only the remainder leaves the unit.
module rdw_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [rdw_pkg::WordWidth-1:0] dividend_i,
  input  wire logic [rdw_pkg::WordWidth-1:0] divisor_i,
  output logic                              done_o,
  output logic [rdw_pkg::WordWidth-1:0]     remainder_o
);

  localparam int unsigned W  = rdw_pkg::WordWidth;
  localparam int unsigned CW = $clog2(W);

  rdw_pkg::div_state_e state_q, state_d;
  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial, diff;
  logic          fits;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    case (state_q)
      rdw_pkg::DIV_IDLE: begin
        if (start_i) begin
          den_d = divisor_i;
          if (dividend_i < divisor_i) begin
            rem_d   = dividend_i;
            quo_d   = '0;
            state_d = rdw_pkg::DIV_DONE;
          end else begin
            rem_d   = '0;
            quo_d   = dividend_i;
            cnt_d   = CW'(W - 1);
            state_d = rdw_pkg::DIV_RUN;
          end
        end
      end
      rdw_pkg::DIV_RUN: begin
        rem_d = fits ? diff[W-1:0] : trial[W-1:0];
        quo_d = {quo_q[W-2:0], fits};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = rdw_pkg::DIV_DONE;
        end
      end
      rdw_pkg::DIV_DONE: begin
        state_d = rdw_pkg::DIV_IDLE;
      end
      default: begin
        state_d = rdw_pkg::DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdw_pkg::DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    cnt_q <= cnt_d;
  end

  assign done_o      = state_q == rdw_pkg::DIV_DONE;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/rdw_mulmod.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add modular multiplier: per multiplier bit, a doubling step and
// an add step, both through one modular adder. Needs a, b < m.
module rdw_mulmod #(
  parameter int unsigned ElemWidth = rdw_pkg::ElemWidthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [ElemWidth-1:0] a_i,
  input  wire logic [ElemWidth-1:0] b_i,
  input  wire logic [ElemWidth-1:0] m_i,
  output logic                      done_o,
  output logic [ElemWidth-1:0]      product_o
);

  localparam int unsigned W  = ElemWidth;
  localparam int unsigned CW = $clog2(W);

  rdw_pkg::mul_state_e state_q, state_d;
  logic [W-1:0]  r_q, r_d, a_q, a_d, b_q, b_d, m_q, m_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  addend, r_next;
  logic [W:0]    sum, red;

  assign addend = (state_q == rdw_pkg::MUL_DBL) ? r_q : a_q;
  assign sum    = {1'b0, r_q} + {1'b0, addend};
  assign red    = (sum >= {1'b0, m_q}) ? sum - {1'b0, m_q} : sum;
  assign r_next = red[W-1:0];

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    a_d     = a_q;
    b_d     = b_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    case (state_q)
      rdw_pkg::MUL_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          b_d     = b_i;
          m_d     = m_i;
          r_d     = '0;
          cnt_d   = CW'(W - 1);
          state_d = rdw_pkg::MUL_DBL;
        end
      end
      rdw_pkg::MUL_DBL: begin
        r_d     = r_next;
        state_d = rdw_pkg::MUL_ADD;
      end
      rdw_pkg::MUL_ADD: begin
        if (b_q[W-1]) begin
          r_d = r_next;
        end
        b_d   = {b_q[W-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        state_d = (cnt_q == '0) ? rdw_pkg::MUL_DONE : rdw_pkg::MUL_DBL;
      end
      rdw_pkg::MUL_DONE: begin
        state_d = rdw_pkg::MUL_IDLE;
      end
      default: begin
        state_d = rdw_pkg::MUL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdw_pkg::MUL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    cnt_q <= cnt_d;
  end

  assign done_o    = state_q == rdw_pkg::MUL_DONE;
  assign product_o = r_q;

endmodule

`default_nettype wire

@@ hw/rtl/rdw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rdw_datapath #(
  parameter int unsigned ElemWidth = rdw_pkg::ElemWidthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire rdw_pkg::dp_cmd_t                 cmd_i,
  output rdw_pkg::dp_status_t                   status_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [rdw_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [rdw_pkg::WordWidth-1:0]    cfg_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [rdw_pkg::OutDataWidth-1:0]      out_data_o,
  output logic                                  out_collided_o
);

  localparam int unsigned EW = ElemWidth;
  localparam int unsigned WW = rdw_pkg::WordWidth;
  localparam int unsigned NW = rdw_pkg::CountWidth;

  function automatic logic [WW-1:0] exp_add(input logic [WW-1:0] a, input logic [WW-1:0] b,
                                            input logic [WW-1:0] n);
    logic [WW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if ((n != '0) && (s >= {1'b0, n})) begin
      s = s - {1'b0, n};
    end
    return s[WW-1:0];
  endfunction

  // configuration
  logic [EW-1:0] mod_q, gen_q, tgt_q;
  logic [WW-1:0] ord_q;
  logic [EW-1:0] eff_p;
  logic          n_zero;

  // walkers, count, modulus latched at restart for the split bounds
  logic [EW-1:0] t_elem_q, h_elem_q, split_p_q;
  logic [WW-1:0] t_ge_q, t_he_q, h_ge_q, h_he_q;
  logic [NW-1:0] count_q;

  // working registers for the current step
  rdw_pkg::step_kind_e kind_q;
  logic [EW-1:0] xr_q, op_q;
  logic [WW-1:0] ge_q, he_q;

  logic [EW-1:0] sel_elem;
  logic [WW-1:0] one_val, ge_new, he_new;

  // x < ceil(p/3) is 3x < p; x < 2*ceil(p/3) is 3*floor(x/2) < p
  logic [EW+1:0] x_tri, half_tri, split_ext;
  logic          below_low, below_up;

  logic          div_start, div_done;
  logic [WW-1:0] div_a, div_b, div_rem;
  logic          mul_start, mul_done;
  logic [EW-1:0] mul_prod;

  logic          out_valid_q;
  logic [rdw_pkg::OutDataWidth-1:0] out_data_q;
  logic          out_coll_q;

  assign eff_p    = (mod_q < EW'(3)) ? EW'(3) : mod_q;
  assign n_zero   = ord_q == '0;
  assign sel_elem = cmd_i.sel ? h_elem_q : t_elem_q;
  assign one_val  = (ord_q == WW'(1)) ? '0 : WW'(1);

  assign x_tri     = {2'b00, sel_elem} + {1'b0, sel_elem, 1'b0};
  assign half_tri  = {3'b000, sel_elem[EW-1:1]} + {2'b00, sel_elem[EW-1:1], 1'b0};
  assign split_ext = {2'b00, split_p_q};
  assign below_low = x_tri < split_ext;
  assign below_up  = half_tri < split_ext;

  always_comb begin
    div_start = 1'b1;
    div_a     = ge_q;
    div_b     = ord_q;
    case (cmd_i.op)
      rdw_pkg::OP_DIV_X: begin
        div_a = WW'(sel_elem);
        div_b = WW'(eff_p);
      end
      rdw_pkg::OP_DIV_OP: begin
        div_b = WW'(eff_p);
        case (kind_q)
          rdw_pkg::KIND_H: div_a = WW'(tgt_q);
          rdw_pkg::KIND_G: div_a = WW'(gen_q);
          default:         div_a = WW'(xr_q);
        endcase
      end
      rdw_pkg::OP_DIV_GE: div_a = ge_q;
      rdw_pkg::OP_DIV_HE: div_a = he_q;
      default:            div_start = 1'b0;
    endcase
  end

  assign mul_start = cmd_i.op == rdw_pkg::OP_MUL;

  rdw_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  rdw_mulmod #(
    .ElemWidth (EW)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (op_q),
    .b_i       (xr_q),
    .m_i       (eff_p),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  always_comb begin
    ge_new = ge_q;
    he_new = he_q;
    case (kind_q)
      rdw_pkg::KIND_H:  he_new = exp_add(he_q, one_val, ord_q);
      rdw_pkg::KIND_SQ: begin
        ge_new = exp_add(ge_q, ge_q, ord_q);
        he_new = exp_add(he_q, he_q, ord_q);
      end
      default:          ge_new = exp_add(ge_q, one_val, ord_q);
    endcase
  end

  // configuration and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q     <= EW'(3);
      ord_q     <= WW'(1);
      gen_q     <= '0;
      tgt_q     <= '0;
      t_elem_q  <= EW'(1);
      h_elem_q  <= EW'(1);
      t_ge_q    <= '0;
      t_he_q    <= '0;
      h_ge_q    <= '0;
      h_he_q    <= '0;
      count_q   <= '0;
      split_p_q <= EW'(3);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rdw_pkg::CFG_MODULUS:     mod_q <= cfg_data_i[EW-1:0];
          rdw_pkg::CFG_GROUP_ORDER: ord_q <= cfg_data_i;
          rdw_pkg::CFG_GENERATOR:   gen_q <= cfg_data_i[EW-1:0];
          rdw_pkg::CFG_TARGET:      tgt_q <= cfg_data_i[EW-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        rdw_pkg::OP_RESTART: begin
          split_p_q <= eff_p;
          t_elem_q  <= EW'(1);
          h_elem_q  <= EW'(1);
          t_ge_q    <= '0;
          t_he_q    <= '0;
          h_ge_q    <= '0;
          h_he_q    <= '0;
          count_q   <= '0;
        end
        rdw_pkg::OP_EXP: begin
          if (cmd_i.sel) begin
            h_elem_q <= mul_prod;
            h_ge_q   <= ge_new;
            h_he_q   <= he_new;
          end else begin
            t_elem_q <= mul_prod;
            t_ge_q   <= ge_new;
            t_he_q   <= he_new;
          end
        end
        rdw_pkg::OP_COUNT: begin
          count_q <= (count_q >= rdw_pkg::CountMax - rdw_pkg::CountStep) ?
                     rdw_pkg::CountMax : count_q + rdw_pkg::CountStep;
        end
        default: ;
      endcase
      if (cmd_i.op == rdw_pkg::OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // step working registers and output payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rdw_pkg::OP_LOAD: begin
        if (below_low) begin
          kind_q <= rdw_pkg::KIND_H;
        end else if (below_up) begin
          kind_q <= rdw_pkg::KIND_SQ;
        end else begin
          kind_q <= rdw_pkg::KIND_G;
        end
        ge_q <= cmd_i.sel ? h_ge_q : t_ge_q;
        he_q <= cmd_i.sel ? h_he_q : t_he_q;
      end
      rdw_pkg::OP_DIV_X:  if (div_done) xr_q <= div_rem[EW-1:0];
      rdw_pkg::OP_DIV_OP: if (div_done) op_q <= div_rem[EW-1:0];
      rdw_pkg::OP_DIV_GE: if (div_done) ge_q <= div_rem;
      rdw_pkg::OP_DIV_HE: if (div_done) he_q <= div_rem;
      rdw_pkg::OP_OUT: begin
        out_data_q <= {count_q, h_he_q, h_ge_q, t_he_q, t_ge_q, WW'(t_elem_q)};
        out_coll_q <= t_elem_q == h_elem_q;
      end
      default: ;
    endcase
  end

  assign status_o = '{div_done: div_done,
                      mul_done: mul_done,
                      n_zero:   n_zero,
                      out_free: !out_valid_q || out_ready_i};

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_collided_o = out_coll_q;

endmodule

`default_nettype wire

@@ hw/rtl/rdw_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rdw_controller (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_restart_i,
  output logic                     in_ready_o,
  input  wire rdw_pkg::dp_status_t status_i,
  output rdw_pkg::dp_cmd_t         cmd_o
);

  rdw_pkg::ctrl_state_e state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       in_fire;
  logic       div_phase;

  assign in_fire   = in_valid_i && (state_q == rdw_pkg::S_IDLE);
  assign div_phase = state_q inside {rdw_pkg::S_DX, rdw_pkg::S_DOP,
                                     rdw_pkg::S_DGE, rdw_pkg::S_DHE};

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      rdw_pkg::S_IDLE: begin
        if (in_fire) begin
          idx_d   = '0;
          state_d = in_restart_i ? rdw_pkg::S_R_SET : rdw_pkg::S_LOAD;
        end
      end
      rdw_pkg::S_R_SET: state_d = rdw_pkg::S_OUT;
      rdw_pkg::S_LOAD:  state_d = rdw_pkg::S_DX;
      rdw_pkg::S_DX:    if (status_i.div_done) state_d = rdw_pkg::S_DOP;
      rdw_pkg::S_DOP:   if (status_i.div_done) state_d = rdw_pkg::S_MUL;
      rdw_pkg::S_MUL: begin
        if (status_i.mul_done) begin
          state_d = status_i.n_zero ? rdw_pkg::S_EXP : rdw_pkg::S_DGE;
        end
      end
      rdw_pkg::S_DGE:   if (status_i.div_done) state_d = rdw_pkg::S_DHE;
      rdw_pkg::S_DHE:   if (status_i.div_done) state_d = rdw_pkg::S_EXP;
      rdw_pkg::S_EXP:   state_d = rdw_pkg::S_NEXT;
      rdw_pkg::S_NEXT: begin
        if (idx_q == rdw_pkg::LastStep) begin
          state_d = rdw_pkg::S_OUT;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = rdw_pkg::S_LOAD;
        end
      end
      rdw_pkg::S_OUT:   if (status_i.out_free) state_d = rdw_pkg::S_IDLE;
      default:          state_d = rdw_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.sel  = idx_q != '0;
    cmd_o.op   = rdw_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      rdw_pkg::S_IDLE:  in_ready_o = 1'b1;
      rdw_pkg::S_R_SET: cmd_o.op = rdw_pkg::OP_RESTART;
      rdw_pkg::S_LOAD:  cmd_o.op = rdw_pkg::OP_LOAD;
      rdw_pkg::S_DX:    cmd_o.op = rdw_pkg::OP_DIV_X;
      rdw_pkg::S_DOP:   cmd_o.op = rdw_pkg::OP_DIV_OP;
      rdw_pkg::S_MUL:   cmd_o.op = rdw_pkg::OP_MUL;
      rdw_pkg::S_DGE:   cmd_o.op = rdw_pkg::OP_DIV_GE;
      rdw_pkg::S_DHE:   cmd_o.op = rdw_pkg::OP_DIV_HE;
      rdw_pkg::S_EXP:   cmd_o.op = rdw_pkg::OP_EXP;
      rdw_pkg::S_NEXT: begin
        if (idx_q == rdw_pkg::LastStep) cmd_o.op = rdw_pkg::OP_COUNT;
      end
      rdw_pkg::S_OUT: begin
        if (status_i.out_free) cmd_o.op = rdw_pkg::OP_OUT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdw_pkg::S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `ASSERT_PROP(a_busy_after_accept, in_fire |=> state_q != rdw_pkg::S_IDLE, "idle after accept")
  `ASSERT_NEVER(a_idx_range, idx_q == 2'd3, "walker index out of range")
  `ASSERT_NEVER(a_div_done_stray, status_i.div_done && !div_phase, "divider done outside a divide")
  `ASSERT_NEVER(a_mul_done_stray, status_i.mul_done && (state_q != rdw_pkg::S_MUL), "stray mul done")

endmodule

`default_nettype wire

@@ hw/rtl/rho_dlog_standard_walk_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pollard rho discrete-log walk with Floyd cycle detection. A tortoise and a
// hare each carry an element x and exponents of g and h; every input
// transaction either restarts both walks (restart = 1) or runs one round of
// one tortoise step and two hare steps, and yields exactly one output
// transaction with the collision flag, the tortoise element, all four
// exponents (reduced mod group_order, or wrapping at 2^64 when it is zero)
// and a saturating step count. Items are handled one at a time. A step goes
// through one shared iterative divider (x mod p, operand mod p, exponents mod
// N; it ends early when the value is already below the divisor) and a
// shift-and-add modular multiplier. The divider reduces x and then the
// operand, the multiplier forms their product, and the divider then reduces
// both exponents, a pass it skips when group_order is zero. A new item is
// accepted while the previous result still waits in the output register.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_data_i (0 modulus,
// 1 group_order, 2 generator, 3 target); the user must write it only while
// the block is idle, as the block does not enforce this. The modulus behind
// the split bounds ceil(p/3) and twice that is latched at restart; a step tests
// 3x < p and 3*floor(x/2) < p, which are the same bounds without a division.
module rho_dlog_standard_walk_unit #(
  parameter int unsigned ElemWidth = rdw_pkg::ElemWidthDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // bit 0: restart
  input  wire logic [rdw_pkg::InDataWidth-1:0]  s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tortoise_value, tortoise_g_exp, tortoise_h_exp, hare_g_exp, hare_h_exp, step_count
  output logic [rdw_pkg::OutDataWidth-1:0]      m_axis_tdata,
  // bit 0: collided
  output logic [0:0]                            m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [rdw_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [rdw_pkg::WordWidth-1:0]    cfg_data_i
);

  rdw_pkg::dp_cmd_t    cmd;
  rdw_pkg::dp_status_t status;

  rdw_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tdata[0]),
    .in_ready_o   (s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rdw_datapath #(
    .ElemWidth (ElemWidth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_collided_o (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

@@ dv/rdw_checker.sv @@
`timescale 1ns / 1ps

module rdw_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid,
  input  logic         in_ready,
  input  logic [7:0]   in_data,
  input  logic         out_valid,
  input  logic         out_ready,
  input  logic [367:0] out_data,
  input  logic [0:0]   out_user,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           results_seen
);

  typedef struct packed {
    logic [63:0] elem;
    logic [63:0] gexp;
    logic [63:0] hexp;
  } walk_t;

  // same bit order as {tuser, tdata}
  typedef struct packed {
    logic        collided;
    logic [47:0] count;
    logic [63:0] h_hexp;
    logic [63:0] h_gexp;
    logic [63:0] t_hexp;
    logic [63:0] t_gexp;
    logic [63:0] t_elem;
  } walk_report_t;

  logic [63:0] p_reg, n_reg, g_reg, h_reg;
  logic [63:0] bound_lo, bound_hi;
  logic [47:0] steps;
  walk_t tort, hare;
  walk_report_t report_q[$];

  function automatic logic [63:0] mod_p();
    return (p_reg < 64'd3) ? 64'd3 : p_reg;
  endfunction

  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, m});
  endfunction

  function automatic logic [63:0] ered(logic [63:0] v);
    return (n_reg == 64'd0) ? v : v % n_reg;
  endfunction

  function automatic logic [63:0] eadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    if (n_reg == 64'd0) return a + b;
    s = {1'b0, ered(a)} + {1'b0, ered(b)};
    if (s >= {1'b0, n_reg}) s = s - {1'b0, n_reg};
    return s[63:0];
  endfunction

  function automatic walk_t walk_step(walk_t w);
    logic [63:0] p, xr;
    walk_t r;
    p = mod_p();
    xr = w.elem % p;
    r = w;
    if (w.elem < bound_lo) begin
      r.elem = mulmod(h_reg % p, xr, p);
      r.hexp = eadd(w.hexp, 64'd1);
      r.gexp = ered(w.gexp);
    end else if (w.elem < bound_hi) begin
      r.elem = mulmod(xr, xr, p);
      r.gexp = eadd(w.gexp, w.gexp);
      r.hexp = eadd(w.hexp, w.hexp);
    end else begin
      r.elem = mulmod(g_reg % p, xr, p);
      r.gexp = eadd(w.gexp, 64'd1);
      r.hexp = ered(w.hexp);
    end
    return r;
  endfunction

  task automatic restart_walks();
    logic [63:0] p, third;
    p = mod_p();
    third = p / 3 + ((p % 3 != 0) ? 64'd1 : 64'd0);
    bound_lo = third;
    bound_hi = third * 2;
    tort = '{64'd1, 64'd0, 64'd0};
    hare = tort;
    steps = '0;
  endtask

  int mismatches;
  walk_report_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_reg = 64'd3; n_reg = 64'd1; g_reg = '0; h_reg = '0;
      restart_walks();
      report_q.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rdw_pkg::CFG_MODULUS:     p_reg = cfg_data;
          rdw_pkg::CFG_GROUP_ORDER: n_reg = cfg_data;
          rdw_pkg::CFG_GENERATOR:   g_reg = cfg_data;
          rdw_pkg::CFG_TARGET:      h_reg = cfg_data;
          default: ;
        endcase
      end
      // output checked before input: the two cannot refer to the same item
      if (out_valid && out_ready) begin
        got = {out_user[0], out_data};
        results_seen++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d mismatch\n  exp %h\n  got %h", results_seen,
                       want, got);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_data[0]) restart_walks();
        else begin
          tort = walk_step(tort);
          hare = walk_step(walk_step(hare));
          steps = (steps >= rdw_pkg::CountMax - 48'd3) ? rdw_pkg::CountMax : steps + 48'd3;
        end
        report_q.push_back('{tort.elem == hare.elem, steps, hare.hexp, hare.gexp,
                             tort.hexp, tort.gexp, tort.elem});
      end
    end
    fail_count = mismatches;
    pending = report_q.size();
  end
endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [367:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_we_i;
  logic [1:0]   cfg_index_i;
  logic [63:0]  cfg_data_i;
  int           fail_count, pending, results_seen;

  rho_dlog_standard_walk_unit dut (.*);

  rdw_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
    .out_user(m_axis_tuser),
    .cfg_we(cfg_we_i), .cfg_index(cfg_index_i), .cfg_data(cfg_data_i),
    .fail_count, .pending, .results_seen
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: stall pattern switches between free-flowing, light and heavy.
  int stall_mode;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  int gap_left;   // idle cycles left before the next burst
  int burst_left; // transactions left in the current burst
  int items_sent;

  // Holds tvalid until the transaction completes; tvalid drops only for a
  // burst gap or a drain.
  task automatic send_item(input logic restart);
    if (gap_left > 0) s_axis_tvalid <= 1'b0;
    while (gap_left > 0) begin
      @(posedge clk_i);
      gap_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'($urandom_range(0, 127)), restart};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end
  endtask

  // Stops sending, waits for the checker to drain, then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  task automatic set_group(input logic [63:0] p, input logic [63:0] n,
                           input logic [63:0] g, input logic [63:0] h);
    drain();
    write_reg(rdw_pkg::CFG_MODULUS, p);
    write_reg(rdw_pkg::CFG_GROUP_ORDER, n);
    write_reg(rdw_pkg::CFG_GENERATOR, g);
    write_reg(rdw_pkg::CFG_TARGET, h);
    cfg_we_i <= 1'b0;
  endtask

  // A walk: restart then a run of rounds; occasionally a stray restart.
  task automatic run_walk(input int rounds);
    send_item(1'b1);
    for (int i = 0; i < rounds; i++) send_item($urandom_range(0, 29) == 0);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Known primes with group order p-1, plus small ones so walks collide.
  logic [63:0] primes [8] = '{64'd1019, 64'd101, 64'd7919, 64'd65521, 64'd4294967291,
                              64'hFFFF_FFFF_FFFF_FFC5, 64'd2147483647, 64'd23};

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    cfg_we_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    stall_mode = 0; gap_left = 0; burst_left = 0; items_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, rounds before any restart.
    send_item(1'b0); send_item(1'b0); send_item(1'b1); send_item(1'b0);
    // Small modulus, zero group order, out-of-range operands.
    set_group(64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    run_walk(4);
    // Largest 64-bit prime, generator above p, order at its extreme.
    set_group(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
              64'hFFFF_FFFF_FFFF_FFFF, 64'd2);
    run_walk(4);
    // Tiny group: collisions, then rounds after a collision.
    set_group(64'd23, 64'd22, 64'd5, 64'd7);
    run_walk(8);
    // Change registers mid-walk (bounds stay latched).
    drain();
    write_reg(rdw_pkg::CFG_MODULUS, 64'd1019);
    write_reg(rdw_pkg::CFG_GENERATOR, 64'd2);
    cfg_we_i <= 1'b0;
    send_item(1'b0); send_item(1'b0);

    // Random walks.
    while (items_sent < 1350) begin
      int k;
      logic [63:0] p;
      k = $urandom_range(0, 9);
      p = (k < 8) ? primes[k] : rand64();
      case ($urandom_range(0, 5))
        0:       set_group(p, 64'd0, rand64(), rand64());
        1:       set_group(p, rand64(), rand64() % p, rand64() % p);
        default: set_group(p, p - 1, rand64() % p, rand64() % p);
      endcase
      run_walk($urandom_range(5, 60));
    end

    // Saturation of the count is beyond reach at this rate (2^48 steps).
    drain();
    $display("Ran %0d transactions over several modulus/order settings, %0d results checked.",
             items_sent, results_seen);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d results pending", pending);
    $display("Some tests failed");
    $finish;
  end
endmodule

@@ rho_dlog_standard_walk_unit.f @@
+incdir+hw/rtl
hw/rtl/rdw_pkg.sv
hw/rtl/rdw_divider.sv
hw/rtl/rdw_mulmod.sv
hw/rtl/rdw_datapath.sv
hw/rtl/rdw_controller.sv
hw/rtl/rho_dlog_standard_walk_unit.sv
dv/rdw_checker.sv
dv/tb_top.sv
